// ===== sv/multi_channel_peak_tracker_defines.svh =====
// ----------------------------------------------------------------------------
// multi_channel_peak_tracker_defines
// Assertion macros used by the peak tracker RTL.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_PEAK_TRACKER_DEFINES_SVH
`define MULTI_CHANNEL_PEAK_TRACKER_DEFINES_SVH

// same-cycle implication
`define MCPT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcpt assertion failed");

// next-cycle implication
`define MCPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcpt assertion failed");

`endif

// ===== sv/mcpt_pkg.sv =====
// ----------------------------------------------------------------------------
// mcpt_pkg
// Types, widths and codes for the multi-channel peak tracker.
// ----------------------------------------------------------------------------
package mcpt_pkg;

  localparam int CHANNELS    = 4;
  localparam int SAMPLE_BITS = 13;

  localparam int CH_W      = 2;
  localparam int LOW_W     = 13;
  localparam int HIGH_W    = 12;
  localparam int PEAK_W    = 13;
  localparam int BEST_CH_W = 3;

  localparam int IN_FIELDS_W  = CH_W + 3 * SAMPLE_BITS + 1;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_PAD_W     = IN_TDATA_W - IN_FIELDS_W;
  localparam int OUT_FIELDS_W = CH_W + 3 * LOW_W + 3 * HIGH_W + 2 * PEAK_W + BEST_CH_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_NO_DATA = 1'b1;

  localparam logic signed [BEST_CH_W-1:0] NO_CHANNEL = BEST_CH_W'(-1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic        [PEAK_W-1:0]      peak_t;
  typedef logic signed [BEST_CH_W-1:0]   best_ch_t;

  typedef struct packed {
    logic            operation;
    logic [CH_W-1:0] channel;
    sample_t         accel_x;
    sample_t         accel_y;
    sample_t         accel_z;
    logic            last_sample;
    logic            last_channel;
  } item_t;

  typedef struct packed {
    logic [CH_W-1:0]          result_channel;
    logic                     channel_valid;
    logic signed [LOW_W-1:0]  x_low;
    logic [HIGH_W-1:0]        x_high;
    logic signed [LOW_W-1:0]  y_low;
    logic [HIGH_W-1:0]        y_high;
    logic signed [LOW_W-1:0]  z_low;
    logic [HIGH_W-1:0]        z_high;
    peak_t                    peak_magnitude;
    peak_t                    sweep_peak;
    best_ch_t                 sweep_peak_channel;
    logic                     sweep_done;
  } result_t;

  typedef struct packed {
    logic    has_result;
    result_t res;
  } trk_out_t;

  // input tdata layout, lowest field last
  typedef struct packed {
    logic [IN_PAD_W-1:0] pad;
    logic                last_channel;
    sample_t             accel_z;
    sample_t             accel_y;
    sample_t             accel_x;
    logic [CH_W-1:0]     channel;
  } in_data_t;

  // output tdata layout, lowest field last
  typedef struct packed {
    logic [OUT_PAD_W-1:0]    pad;
    best_ch_t                sweep_peak_channel;
    peak_t                   sweep_peak;
    peak_t                   peak_magnitude;
    logic [HIGH_W-1:0]       z_high;
    logic signed [LOW_W-1:0] z_low;
    logic [HIGH_W-1:0]       y_high;
    logic signed [LOW_W-1:0] y_low;
    logic [HIGH_W-1:0]       x_high;
    logic signed [LOW_W-1:0] x_low;
    logic [CH_W-1:0]         result_channel;
  } out_data_t;

  function automatic peak_t mag_low(sample_t v);
    logic signed [SAMPLE_BITS:0] w;
    w = -{v[SAMPLE_BITS-1], v};
    return PEAK_W'(w);
  endfunction

  function automatic peak_t max_u(peak_t a, peak_t b);
    return (b > a) ? b : a;
  endfunction

endpackage

// ===== sv/mcpt_tracker.sv =====
// ----------------------------------------------------------------------------
// mcpt_tracker
// Running per-axis limits, peak magnitude and sweep best for one item.
// ----------------------------------------------------------------------------
module mcpt_tracker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  mcpt_pkg::item_t   item,
  output mcpt_pkg::trk_out_t trk
);
  import mcpt_pkg::*;

  `include "multi_channel_peak_tracker_defines.svh"

  sample_t  run_x_lo_r, run_x_hi_r, run_y_lo_r, run_y_hi_r, run_z_lo_r, run_z_hi_r;
  peak_t    best_peak_r;
  best_ch_t best_ch_r;

  sample_t  x_lo_nxt, x_hi_nxt, y_lo_nxt, y_hi_nxt, z_lo_nxt, z_hi_nxt;
  peak_t    peak;
  logic     chan_ok, valid, better;
  best_ch_t this_ch;

  assign chan_ok = (int'(item.channel) < CHANNELS);
  assign valid   = (item.operation == OP_SAMPLE);
  assign this_ch = BEST_CH_W'({1'b0, item.channel});

  always_comb begin
    x_lo_nxt = (item.accel_x < run_x_lo_r) ? item.accel_x : run_x_lo_r;
    x_hi_nxt = (item.accel_x > run_x_hi_r) ? item.accel_x : run_x_hi_r;
    y_lo_nxt = (item.accel_y < run_y_lo_r) ? item.accel_y : run_y_lo_r;
    y_hi_nxt = (item.accel_y > run_y_hi_r) ? item.accel_y : run_y_hi_r;
    z_lo_nxt = (item.accel_z < run_z_lo_r) ? item.accel_z : run_z_lo_r;
    z_hi_nxt = (item.accel_z > run_z_hi_r) ? item.accel_z : run_z_hi_r;
    peak = max_u(max_u(max_u(PEAK_W'(x_hi_nxt), PEAK_W'(y_hi_nxt)),
                       max_u(PEAK_W'(z_hi_nxt), mag_low(x_lo_nxt))),
                 max_u(mag_low(y_lo_nxt), mag_low(z_lo_nxt)));
    better = (peak > best_peak_r);
  end

  always_comb begin
    trk.has_result             = chan_ok && (!valid || item.last_sample);
    trk.res.result_channel     = item.channel;
    trk.res.channel_valid      = valid;
    trk.res.sweep_done         = item.last_channel;
    if (valid) begin
      trk.res.x_low              = LOW_W'(x_lo_nxt);
      trk.res.x_high             = HIGH_W'(x_hi_nxt);
      trk.res.y_low              = LOW_W'(y_lo_nxt);
      trk.res.y_high             = HIGH_W'(y_hi_nxt);
      trk.res.z_low              = LOW_W'(z_lo_nxt);
      trk.res.z_high             = HIGH_W'(z_hi_nxt);
      trk.res.peak_magnitude     = peak;
      trk.res.sweep_peak         = better ? peak : best_peak_r;
      trk.res.sweep_peak_channel = better ? this_ch : best_ch_r;
    end else begin
      trk.res.x_low              = '0;
      trk.res.x_high             = '0;
      trk.res.y_low              = '0;
      trk.res.y_high             = '0;
      trk.res.z_low              = '0;
      trk.res.z_high             = '0;
      trk.res.peak_magnitude     = '0;
      trk.res.sweep_peak         = best_peak_r;
      trk.res.sweep_peak_channel = best_ch_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_x_lo_r  <= '0;
      run_x_hi_r  <= '0;
      run_y_lo_r  <= '0;
      run_y_hi_r  <= '0;
      run_z_lo_r  <= '0;
      run_z_hi_r  <= '0;
      best_peak_r <= '0;
      best_ch_r   <= NO_CHANNEL;
    end else if (step && chan_ok) begin
      if (valid && !item.last_sample) begin
        run_x_lo_r <= x_lo_nxt;
        run_x_hi_r <= x_hi_nxt;
        run_y_lo_r <= y_lo_nxt;
        run_y_hi_r <= y_hi_nxt;
        run_z_lo_r <= z_lo_nxt;
        run_z_hi_r <= z_hi_nxt;
      end else begin
        run_x_lo_r <= '0;
        run_x_hi_r <= '0;
        run_y_lo_r <= '0;
        run_y_hi_r <= '0;
        run_z_lo_r <= '0;
        run_z_hi_r <= '0;
        if (item.last_channel) begin
          best_peak_r <= '0;
          best_ch_r   <= NO_CHANNEL;
        end else if (valid && better) begin
          best_peak_r <= peak;
          best_ch_r   <= this_ch;
        end
      end
    end
  end

  `MCPT_ASSERT_NEXT(a_sweep_clear, step && trk.has_result && item.last_channel,
                    best_peak_r == '0 && best_ch_r == NO_CHANNEL)
  `MCPT_ASSERT_NEXT(a_run_clear, step && trk.has_result,
                    run_x_lo_r == '0 && run_x_hi_r == '0 && run_y_lo_r == '0 &&
                    run_y_hi_r == '0 && run_z_lo_r == '0 && run_z_hi_r == '0)
  `MCPT_ASSERT_IMPL(a_best_pair, 1'b1, (best_peak_r == '0) == (best_ch_r == NO_CHANNEL))
  `MCPT_ASSERT_IMPL(a_peak_bound, trk.has_result && trk.res.channel_valid,
                    trk.res.peak_magnitude <= trk.res.sweep_peak)

endmodule

// ===== sv/multi_channel_peak_tracker.sv =====
// An accepted request is held in the input register, and its result is then
// held in the result register.
// One request is taken per cycle while no result is held up by out_tready.
// Samples that are not last in a block give no result.
// Reset (rst_n low, synchronous) empties both registers, zeroes the running
// limits and best peak, and sets the best channel to none.
// ----------------------------------------------------------------------------
// multi_channel_peak_tracker
// Input register, tracker and result register for per-channel peak tracking.
// ----------------------------------------------------------------------------
module multi_channel_peak_tracker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // channel, accel_x, accel_y, accel_z, last_channel, zero pad
  input  logic [mcpt_pkg::IN_TDATA_W-1:0]  in_tdata,
  // operation
  input  logic                             in_tuser,
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // result_channel, x_low, x_high, y_low, y_high, z_low, z_high,
  // peak_magnitude, sweep_peak, sweep_peak_channel, zero pad
  output logic [mcpt_pkg::OUT_TDATA_W-1:0] out_tdata,
  // channel_valid
  output logic                             out_tuser,
  output logic                             out_tlast
);
  import mcpt_pkg::*;

  item_t     item_r;
  result_t   res_r;
  logic      in_valid_r, out_valid_r;
  trk_out_t  trk;
  in_data_t  in_d;
  out_data_t out_d;
  logic      fire, out_free;

  assign in_d      = in_data_t'(in_tdata);
  assign out_free  = !out_valid_r || out_tready;
  assign fire      = in_valid_r && (!trk.has_result || out_free);
  assign in_tready = !in_valid_r || fire;

  mcpt_tracker u_tracker (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (fire),
    .item  (item_r),
    .trk   (trk)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (fire && trk.has_result) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.operation    <= in_tuser;
      item_r.channel      <= in_d.channel;
      item_r.accel_x      <= in_d.accel_x;
      item_r.accel_y      <= in_d.accel_y;
      item_r.accel_z      <= in_d.accel_z;
      item_r.last_sample  <= in_tlast;
      item_r.last_channel <= in_d.last_channel;
    end
    if (fire && trk.has_result) begin
      res_r <= trk.res;
    end
  end

  always_comb begin
    out_d.pad                = '0;
    out_d.result_channel     = res_r.result_channel;
    out_d.x_low              = res_r.x_low;
    out_d.x_high             = res_r.x_high;
    out_d.y_low              = res_r.y_low;
    out_d.y_high             = res_r.y_high;
    out_d.z_low              = res_r.z_low;
    out_d.z_high             = res_r.z_high;
    out_d.peak_magnitude     = res_r.peak_magnitude;
    out_d.sweep_peak         = res_r.sweep_peak;
    out_d.sweep_peak_channel = res_r.sweep_peak_channel;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_d;
  assign out_tuser  = res_r.channel_valid;
  assign out_tlast  = res_r.sweep_done;

endmodule
